>>> hw/rtl/svt_pkg.sv
package svt_pkg;

    localparam int COORD_W   = 32;
    localparam int TRIG_W    = 16;
    localparam int WIDTH_W   = 16;
    localparam int TEXW_W    = 13;
    localparam int COL_W     = 12;
    localparam int ANGLE_W   = 16;
    localparam int HALF_W    = 12;
    // view coordinate before saturation
    localparam int VIEW_W    = 37;
    // CORDIC datapath
    localparam int CX_W      = 44;
    localparam int CZ_W      = 34;
    localparam int MAG_W     = 38;
    localparam int SHIFT_W   = 6;
    localparam int NORM_BIT  = 40;

    localparam logic [16:0]     DIV20_RECIP  = 17'd52429;
    localparam logic [31:0]     HALF_PI_Q30  = 32'd1686629713;
    localparam logic [ANGLE_W-1:0] ANGLE_PI_Q14 = 16'd51472;

    typedef struct packed {
        logic signed [COORD_W-1:0] viewer_x;
        logic signed [COORD_W-1:0] viewer_y;
        logic signed [TRIG_W-1:0]  viewer_sine;
        logic signed [TRIG_W-1:0]  viewer_cosine;
        logic signed [COORD_W-1:0] sprite_x;
        logic signed [COORD_W-1:0] sprite_y;
        logic [WIDTH_W-1:0]        sprite_width;
        logic [TEXW_W-1:0]         texture_width;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_end1_x;
        logic signed [COORD_W-1:0] world_end1_y;
        logic signed [COORD_W-1:0] world_end2_x;
        logic signed [COORD_W-1:0] world_end2_y;
        logic signed [COORD_W-1:0] view_end1_x;
        logic signed [COORD_W-1:0] view_end1_y;
        logic signed [COORD_W-1:0] view_end2_x;
        logic signed [COORD_W-1:0] view_end2_y;
        logic [ANGLE_W-1:0]        angle_end1;
        logic [ANGLE_W-1:0]        angle_end2;
        logic [COL_W-1:0]          last_column;
    } t_out;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic                   zero;
    } t_cordic;

    function automatic logic [31:0] f_atan(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32 bit range
    function automatic logic signed [COORD_W-1:0] f_sat32(input logic signed [39:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/svt_cordic_cell.sv
module svt_cordic_cell
    import svt_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_v,
    output t_cordic o_v
);

    localparam logic [31:0] ATAN = f_atan(STAGE);

    t_cordic r_v;
    t_cordic n_v;
    logic signed [CX_W-1:0] sx;
    logic signed [CX_W-1:0] sy;

    always_comb begin
        sx = i_v.x >>> STAGE;
        sy = i_v.y >>> STAGE;
        n_v.zero = i_v.zero;
        if (!i_v.y[CX_W-1] && (|i_v.y)) begin
            n_v.x = i_v.x + sy;
            n_v.y = i_v.y - sx;
            n_v.z = i_v.z + $signed({2'b00, ATAN});
        end else begin
            n_v.x = i_v.x - sy;
            n_v.y = i_v.y + sx;
            n_v.z = i_v.z - $signed({2'b00, ATAN});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

>>> hw/rtl/svt_angle_unit.sv
module svt_angle_unit
    import svt_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [VIEW_W-1:0]  i_x,
    input  logic signed [VIEW_W-1:0]  i_y,
    output logic [ANGLE_W-1:0]        o_angle
);

    logic signed [MAG_W-1:0] ax;
    logic signed [MAG_W-1:0] ny;
    logic [MAG_W-1:0]        n_mx;
    logic [MAG_W-1:0]        n_my;
    logic [MAG_W-1:0]        mor;
    logic [SHIFT_W-1:0]      top_bit;
    logic [MAG_W-1:0]        r_mx;
    logic [MAG_W-1:0]        r_my;
    logic [SHIFT_W-1:0]      r_shift;
    logic                    r_quad;
    logic                    r_zero;
    t_cordic                 chain [0:CORDIC_STAGES];
    t_cordic                 r_norm;
    logic signed [CZ_W-1:0]  zf;
    logic [CZ_W-1:0]         zr;
    logic [ANGLE_W-1:0]      n_angle;
    logic [ANGLE_W-1:0]      r_angle;

    // fold onto (y, |x|), quarter turn when y is negative, find the top bit
    always_comb begin
        ax = i_x[VIEW_W-1] ? -{i_x[VIEW_W-1], i_x} : {i_x[VIEW_W-1], i_x};
        ny = -{i_y[VIEW_W-1], i_y};
        if (i_y[VIEW_W-1]) begin
            n_mx = ax;
            n_my = ny;
        end else begin
            n_mx = {i_y[VIEW_W-1], i_y};
            n_my = ax;
        end
        mor = n_mx | n_my;
        top_bit = '0;
        for (int j = 0; j < MAG_W; j++) begin
            if (mor[j]) begin
                top_bit = SHIFT_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_quad  <= i_y[VIEW_W-1];
            r_zero  <= (ax == '0) && (i_y == '0);
            r_shift <= SHIFT_W'(NORM_BIT) - top_bit;
        end
    end

    // normalize so the larger component sits at the norm bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm.x    <= $signed(CX_W'(r_mx) << r_shift);
            r_norm.y    <= $signed(CX_W'(r_my) << r_shift);
            r_norm.z    <= r_quad ? $signed({2'b00, HALF_PI_Q30}) : '0;
            r_norm.zero <= r_zero;
        end
    end

    assign chain[0] = r_norm;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        svt_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (chain[g]),
            .o_v   (chain[g+1])
        );
    end

    always_comb begin
        zf = chain[CORDIC_STAGES].z;
        zr = $unsigned(zf) + CZ_W'(32768);
        if (chain[CORDIC_STAGES].zero || zf[CZ_W-1]) begin
            n_angle = '0;
        end else if ((zr >> 16) > CZ_W'(ANGLE_PI_Q14)) begin
            n_angle = ANGLE_PI_Q14;
        end else begin
            n_angle = zr[16 +: ANGLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

>>> hw/rtl/sprite_view_transform.sv
// Sprite billboard transform.
// Input channel i_in_valid / o_in_ready carries one sprite request (viewer
// position, heading as sine and cosine, sprite centre, width, texture width).
// Output channel o_out_valid / i_out_ready returns one result per request:
// rotated world ends, view-space ends, the view angle of each end and the
// last texture column.
// Segment build and rotation are registered in the r1 to r4 stages, then
// per end the angle unit has a fold register, a normalize register, one
// CORDIC cell per stage and a rounding register.
// Throughput is one request per clock while the receiver does not stall; every stage is a register stage and
// the CORDIC runs as a chain of cells, one cell per iteration.
// When the receiver stalls with a result pending, the whole pipeline holds
// and o_in_ready drops in the same cycle; it resumes as soon as the result
// is taken. Synchronous reset clears all valid flags; payload registers are
// not reset. Requests in flight at reset are dropped.
module sprite_view_transform
    import svt_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int LAT      = CORDIC_STAGES + 7;
    localparam int SIDE_LEN = CORDIC_STAGES + 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] w1x;
        logic signed [COORD_W-1:0] w1y;
        logic signed [COORD_W-1:0] w2x;
        logic signed [COORD_W-1:0] w2y;
        logic signed [COORD_W-1:0] v1x;
        logic signed [COORD_W-1:0] v1y;
        logic signed [COORD_W-1:0] v2x;
        logic signed [COORD_W-1:0] v2y;
        logic [COL_W-1:0]          lc;
    } t_side;

    logic en;
    logic [LAT-1:0] r_vld;

    // stage 1
    logic [32:0]               h_prod;
    logic [HALF_W-1:0]         r1_h;
    logic signed [32:0]        r1_dx, r1_dy;
    logic signed [TRIG_W-1:0]  r1_s, r1_c;
    logic signed [COORD_W-1:0] r1_sx, r1_sy;
    logic [COL_W-1:0]          r1_lc;
    // stage 2
    logic signed [28:0]        os, oc;
    logic signed [33:0]        os4, oc4;
    logic signed [33:0]        r2_t1x, r2_t1y, r2_t2x, r2_t2y;
    logic signed [TRIG_W-1:0]  r2_s, r2_c;
    logic signed [COORD_W-1:0] r2_w1x, r2_w1y, r2_w2x, r2_w2y;
    logic [COL_W-1:0]          r2_lc;
    // stage 3
    logic signed [49:0]        r3_p1xs, r3_p1yc, r3_p1xc, r3_p1ys;
    logic signed [49:0]        r3_p2xs, r3_p2yc, r3_p2xc, r3_p2ys;
    logic signed [COORD_W-1:0] r3_w1x, r3_w1y, r3_w2x, r3_w2y;
    logic [COL_W-1:0]          r3_lc;
    // stage 4
    logic signed [50:0]        q1x, q1y, q2x, q2y;
    logic signed [VIEW_W-1:0]  r4_1x, r4_1y, r4_2x, r4_2y;
    logic signed [COORD_W-1:0] r4_w1x, r4_w1y, r4_w2x, r4_w2y;
    logic [COL_W-1:0]          r4_lc;

    t_side                     r_side [0:SIDE_LEN-1];
    t_side                     side_in;
    logic [ANGLE_W-1:0]        angle1, angle2;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // width / 20 by reciprocal multiply
    assign h_prod = 33'(i_in_data.sprite_width * DIV20_RECIP);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_h  <= h_prod[20 +: HALF_W];
            r1_dx <= {i_in_data.sprite_x[31], i_in_data.sprite_x}
                   - {i_in_data.viewer_x[31], i_in_data.viewer_x};
            r1_dy <= {i_in_data.sprite_y[31], i_in_data.sprite_y}
                   - {i_in_data.viewer_y[31], i_in_data.viewer_y};
            r1_s  <= i_in_data.viewer_sine;
            r1_c  <= i_in_data.viewer_cosine;
            r1_sx <= i_in_data.sprite_x;
            r1_sy <= i_in_data.sprite_y;
            r1_lc <= COL_W'(i_in_data.texture_width - TEXW_W'(1));
        end
    end

    assign os  = $signed({1'b0, r1_h}) * r1_s;
    assign oc  = $signed({1'b0, r1_h}) * r1_c;
    assign os4 = 34'(os) <<< 2;
    assign oc4 = 34'(oc) <<< 2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t1x <= 34'(r1_dx) + os4;
            r2_t1y <= 34'(r1_dy) - oc4;
            r2_t2x <= 34'(r1_dx) - os4;
            r2_t2y <= 34'(r1_dy) + oc4;
            r2_w1x <= f_sat32(40'(r1_sx) + 40'(os4));
            r2_w1y <= f_sat32(40'(r1_sy) - 40'(oc4));
            r2_w2x <= f_sat32(40'(r1_sx) - 40'(os4));
            r2_w2y <= f_sat32(40'(r1_sy) + 40'(oc4));
            r2_s   <= r1_s;
            r2_c   <= r1_c;
            r2_lc  <= r1_lc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p1xs <= r2_t1x * r2_s;
            r3_p1yc <= r2_t1y * r2_c;
            r3_p1xc <= r2_t1x * r2_c;
            r3_p1ys <= r2_t1y * r2_s;
            r3_p2xs <= r2_t2x * r2_s;
            r3_p2yc <= r2_t2y * r2_c;
            r3_p2xc <= r2_t2x * r2_c;
            r3_p2ys <= r2_t2y * r2_s;
            r3_w1x  <= r2_w1x;
            r3_w1y  <= r2_w1y;
            r3_w2x  <= r2_w2x;
            r3_w2y  <= r2_w2y;
            r3_lc   <= r2_lc;
        end
    end

    // round half up from Q.30 to Q16.16
    assign q1x = 51'(r3_p1xs) - 51'(r3_p1yc) + 51'sd8192;
    assign q1y = 51'(r3_p1xc) + 51'(r3_p1ys) + 51'sd8192;
    assign q2x = 51'(r3_p2xs) - 51'(r3_p2yc) + 51'sd8192;
    assign q2y = 51'(r3_p2xc) + 51'(r3_p2ys) + 51'sd8192;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_1x  <= q1x[14 +: VIEW_W];
            r4_1y  <= q1y[14 +: VIEW_W];
            r4_2x  <= q2x[14 +: VIEW_W];
            r4_2y  <= q2y[14 +: VIEW_W];
            r4_w1x <= r3_w1x;
            r4_w1y <= r3_w1y;
            r4_w2x <= r3_w2x;
            r4_w2y <= r3_w2y;
            r4_lc  <= r3_lc;
        end
    end

    always_comb begin
        side_in.w1x = r4_w1x;
        side_in.w1y = r4_w1y;
        side_in.w2x = r4_w2x;
        side_in.w2y = r4_w2y;
        side_in.v1x = f_sat32(40'(r4_1x));
        side_in.v1y = f_sat32(40'(r4_1y));
        side_in.v2x = f_sat32(40'(r4_2x));
        side_in.v2y = f_sat32(40'(r4_2y));
        side_in.lc  = r4_lc;
    end

    // hold the remaining fields alongside the angle units
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_in;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    svt_angle_unit #(.CORDIC_STAGES(CORDIC_STAGES)) u_angle1 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r4_1x),
        .i_y     (r4_1y),
        .o_angle (angle1)
    );

    svt_angle_unit #(.CORDIC_STAGES(CORDIC_STAGES)) u_angle2 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r4_2x),
        .i_y     (r4_2y),
        .o_angle (angle2)
    );

    always_comb begin
        o_out_data.world_end1_x = r_side[SIDE_LEN-1].w1x;
        o_out_data.world_end1_y = r_side[SIDE_LEN-1].w1y;
        o_out_data.world_end2_x = r_side[SIDE_LEN-1].w2x;
        o_out_data.world_end2_y = r_side[SIDE_LEN-1].w2y;
        o_out_data.view_end1_x  = r_side[SIDE_LEN-1].v1x;
        o_out_data.view_end1_y  = r_side[SIDE_LEN-1].v1y;
        o_out_data.view_end2_x  = r_side[SIDE_LEN-1].v2x;
        o_out_data.view_end2_y  = r_side[SIDE_LEN-1].v2y;
        o_out_data.angle_end1   = angle1;
        o_out_data.angle_end2   = angle2;
        o_out_data.last_column  = r_side[SIDE_LEN-1].lc;
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_angle1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.angle_end1 <= ANGLE_PI_Q14)
        else $error("angle_end1 above pi");

    a_angle2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.angle_end2 <= ANGLE_PI_Q14)
        else $error("angle_end2 above pi");

    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.view_end1_x == '0 && o_out_data.view_end1_y == '0)
        |-> o_out_data.angle_end1 == '0)
        else $error("nonzero angle for zero view vector");

endmodule

>>> verif/testbench.sv
module testbench
    import svt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES      = 16;
    localparam int LATENCY     = STAGES + 7;
    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint NORM_LIMIT = 64'sd1 << 40;
    localparam longint HALF_PI    = 64'sd1686629713;
    localparam longint ANGLE_MAX  = 64'sd51472;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_in  pending_req[$];
    t_out expected_res[$];
    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;
    bit   stim_done = 1'b0;
    bit   idle_on = 1'b1;
    bit   hold_send = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;

    sprite_view_transform #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((-v + (64'sd1 << s) - 1) >>> s);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint arctan_q30(int i);
        longint tbl[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tbl[i];
    endfunction

    // atan2(|x|, y) in Q2.14
    function automatic logic [15:0] end_angle(longint x, longint y);
        longint ax, cx, cy, z, nx, ny, r;
        ax = (x < 0) ? -x : x;
        z = 0;
        if (ax == 0 && y == 0) begin
            return 16'd0;
        end
        cx = y;
        cy = ax;
        if (cx < 0) begin
            cx = ax;
            cy = -y;
            z = HALF_PI;
        end
        while (cx < NORM_LIMIT && cy < NORM_LIMIT) begin
            cx = cx * 2;
            cy = cy * 2;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (cy > 0) begin
                nx = cx + floor_shr(cy, i);
                ny = cy - floor_shr(cx, i);
                z += arctan_q30(i);
            end else begin
                nx = cx - floor_shr(cy, i);
                ny = cy + floor_shr(cx, i);
                z -= arctan_q30(i);
            end
            cx = nx;
            cy = ny;
        end
        if (z < 0) begin
            z = 0;
        end
        r = (z + 32768) >>> 16;
        if (r > ANGLE_MAX) begin
            r = ANGLE_MAX;
        end
        return r[15:0];
    endfunction

    function automatic t_out billboard(t_in q);
        t_out o;
        longint s, c, h, os, oc, dx, dy, t1x, t1y, t2x, t2y, r1x, r1y, r2x, r2y;
        s  = longint'(q.viewer_sine);
        c  = longint'(q.viewer_cosine);
        h  = longint'(q.sprite_width) / 20;
        os = h * s * 4;
        oc = h * c * 4;
        dx = longint'(q.sprite_x) - longint'(q.viewer_x);
        dy = longint'(q.sprite_y) - longint'(q.viewer_y);
        t1x = dx + os;
        t1y = dy - oc;
        t2x = dx - os;
        t2y = dy + oc;
        r1x = floor_shr(t1x * s - t1y * c + 8192, 14);
        r1y = floor_shr(t1x * c + t1y * s + 8192, 14);
        r2x = floor_shr(t2x * s - t2y * c + 8192, 14);
        r2y = floor_shr(t2x * c + t2y * s + 8192, 14);
        o.world_end1_x = clamp32(longint'(q.sprite_x) + os);
        o.world_end1_y = clamp32(longint'(q.sprite_y) - oc);
        o.world_end2_x = clamp32(longint'(q.sprite_x) - os);
        o.world_end2_y = clamp32(longint'(q.sprite_y) + oc);
        o.view_end1_x  = clamp32(r1x);
        o.view_end1_y  = clamp32(r1y);
        o.view_end2_x  = clamp32(r2x);
        o.view_end2_y  = clamp32(r2y);
        o.angle_end1   = end_angle(r1x, r1y);
        o.angle_end2   = end_angle(r2x, r2y);
        o.last_column  = 12'(q.texture_width - 13'd1);
        return o;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000)
                      ^ $urandom_range(0, 255);
            default: return 32'($signed($urandom_range(0, 32'h01FFFFFF))
                      - 32'sh00FFFFFF);
        endcase
    endfunction

    function automatic logic [15:0] rand_trig();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_in rand_req();
        t_in q;
        real a;
        q.viewer_x = rand_coord();
        q.viewer_y = rand_coord();
        if ($urandom_range(0, 3) != 0) begin
            // coherent heading
            a = $urandom_range(0, 62831) / 10000.0;
            q.viewer_sine   = 16'($rtoi($sin(a) * 16384.0));
            q.viewer_cosine = 16'($rtoi($cos(a) * 16384.0));
        end else begin
            q.viewer_sine   = rand_trig();
            q.viewer_cosine = rand_trig();
        end
        q.sprite_x = rand_coord();
        q.sprite_y = rand_coord();
        if ($urandom_range(0, 1)) begin
            q.sprite_x = q.viewer_x + $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh7FFFFF;
            q.sprite_y = q.viewer_y + $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh7FFFFF;
        end
        q.sprite_width  = $urandom_range(0, 3) == 0 ? 16'($urandom())
                                                    : 16'($urandom_range(0, 2000));
        q.texture_width = $urandom_range(0, 7) == 0 ? 13'($urandom())
                                                    : 13'($urandom_range(1, 4096));
        return q;
    endfunction

    function automatic t_in make_req(logic [31:0] vx, logic [31:0] vy, logic [15:0] s,
                                     logic [15:0] c, logic [31:0] sx, logic [31:0] sy,
                                     logic [15:0] w, logic [12:0] tw);
        t_in q;
        q = '{vx, vy, s, c, sx, sy, w, tw};
        return q;
    endfunction

    initial begin
        // extremes, quadrants, zero-length view, overflow, bad trig, texture widths
        pending_req.push_back(make_req(0, 0, 0, 16384, 0, 0, 0, 1));
        pending_req.push_back(make_req(0, 0, 16384, 0, 32'h10000, 0, 40, 4096));
        pending_req.push_back(make_req(0, 0, 0, -16384, 0, 32'h50000, 19, 0));
        pending_req.push_back(make_req(0, 0, -16384, 0, 0, -32'sh50000, 20, 8191));
        pending_req.push_back(make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 16384, 16384,
                                       32'h80000000, 32'h80000000, 16'hFFFF, 4097));
        pending_req.push_back(make_req(32'h80000000, 32'h80000000, -16384, -16384,
                                       32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 2));
        pending_req.push_back(make_req(0, 0, 16'h8000, 16'h7FFF, 32'h7FFFFFFF,
                                       32'h80000000, 16'hFFFF, 13'h1555));
        pending_req.push_back(make_req(0, 0, 16'h7FFF, 16'h8000, 0, 0, 16'hFFFF, 13'h0AAA));
        pending_req.push_back(make_req(32'h12345678, 32'h9ABCDEF0, 11585, 11585,
                                       32'h12345678, 32'h9ABCDEF0, 0, 100));
        pending_req.push_back(make_req(32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA,
                                       32'hAAAAAAAA, 32'h55555555, 16'h5555, 13'h1555));
        pending_req.push_back(make_req(0, 0, 0, 0, 32'h10000, 32'h10000, 1000, 64));
        pending_req.push_back(make_req(0, 0, 8192, 14189, -32'sh30000, 32'h1, 60, 4096));
        pending_req.push_back(make_req(0, 0, -8192, 14189, 32'h1, -32'sh1, 21, 1));
        for (int i = 0; i < N_RANDOM; i++) begin
            pending_req.push_back(rand_req());
            if (i == N_RANDOM / 2) begin
                wait (pending_req.size() == 0);
                hold_send = 1'b1;
                wait (expected_res.size() == 0 && !i_in_valid);
                hold_send = 1'b0;
            end
        end
        // no idling over the last quarter of the run
        wait (pending_req.size() <= N_RANDOM / 4);
        idle_on = 1'b0;
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_res.push_back(billboard(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 15);
                    i_in_valid <= 1'b0;
                end else if (!hold_send && pending_req.size() > 0) begin
                    i_in_data  <= pending_req.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_res.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected result %h", o_out_data);
                    end
                end else begin
                    exp_res = expected_res.pop_front();
                    if (o_out_data !== exp_res) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected %h actual %h", exp_res, o_out_data);
                        end
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                recv_gap <= $urandom_range(1, 15);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_req.size() == 0 && !i_in_valid);
        wait (expected_res.size() == 0);
        repeat (LATENCY * 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_res.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/svt_pkg.sv
hw/rtl/svt_cordic_cell.sv
hw/rtl/svt_angle_unit.sv
hw/rtl/sprite_view_transform.sv
verif/testbench.sv
